FILE: src/vpr_pkg.sv
// shared constants and types for the vector projection / rejection block
package vpr_pkg;
    localparam int FIELD_W    = 32;
    localparam int HALF_W     = 32;
    localparam int CLAMP_BITS = 40;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BZERO = 2'd1,
        ST_SAT   = 2'd2
    } t_status;
endpackage

FILE: src/vpr_dot.sv
// dot products, magnitude and sign of dot(a,b): three pipeline stages
module vpr_dot #(
    parameter int W   = 32,
    parameter int F   = 16,
    parameter int DW  = 2 * W,
    parameter int NW  = 2 * W + F,
    parameter int SBW = 6 * W + 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic                i_mode,
    input  logic                i_be,
    input  logic [2:0][W-1:0]   i_a,
    input  logic [2:0][W-1:0]   i_b,
    output logic                o_valid,
    output logic [NW-1:0]       o_num,
    output logic [DW-1:0]       o_d,
    output logic [SBW-1:0]      o_sb
);
    import vpr_pkg::*;

    localparam int SW = DW + 2;

    logic                r1_valid, r2_valid, r3_valid;
    logic signed [DW-1:0] r1_ab [3];
    logic        [DW-1:0] r1_bb [3];
    logic signed [DW-1:0] n1_ab [3];
    logic        [DW-1:0] n1_bb [3];
    logic [2:0][W-1:0]   r1_a, r1_b, r2_a, r2_b, r3_a, r3_b;
    logic                r1_mode, r2_mode, r3_mode;
    logic                r1_be, r2_be, r3_be;
    logic signed [SW-1:0] r2_dot, n2_dot;
    logic [DW-1:0]       r2_bb, n2_bb, r3_d;
    logic signed [SW-1:0] n3_mag;
    logic [NW-1:0]       r3_num;
    logic                r3_neg, r3_bzero;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_ab[i] = $signed(i_a[i]) * $signed(i_b[i]);
            n1_bb[i] = $signed(i_b[i]) * $signed(i_b[i]);
        end
    end

    always_comb begin
        n2_dot = SW'(r1_ab[0]) + SW'(r1_ab[1]) + SW'(r1_ab[2]);
        n2_bb  = r1_bb[0] + r1_bb[1] + r1_bb[2];
        n3_mag = r2_dot[SW-1] ? -r2_dot : r2_dot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_ab[i] <= n1_ab[i];
                r1_bb[i] <= n1_bb[i];
            end
            r1_a      <= i_a;
            r1_b      <= i_b;
            r1_mode   <= i_mode;
            r1_be     <= i_be;
            r2_dot    <= n2_dot;
            r2_bb     <= n2_bb;
            r2_a      <= r1_a;
            r2_b      <= r1_b;
            r2_mode   <= r1_mode;
            r2_be     <= r1_be;
            r3_num    <= {n3_mag[DW-1:0], {F{1'b0}}};
            r3_d      <= r2_bb;
            r3_neg    <= r2_dot[SW-1];
            r3_bzero  <= (r2_bb == '0);
            r3_a      <= r2_a;
            r3_b      <= r2_b;
            r3_mode   <= r2_mode;
            r3_be     <= r2_be;
        end
    end

    assign o_valid = r3_valid;
    assign o_num   = r3_num;
    assign o_d     = r3_d;
    assign o_sb    = {r3_mode, r3_be, r3_bzero, r3_neg, r3_a, r3_b};
endmodule

FILE: src/vpr_div_stage.sv
// one restoring-division step: one quotient bit per stage
module vpr_div_stage #(
    parameter int DW  = 64,
    parameter int NW  = 80,
    parameter int QW  = 64,
    parameter int SBW = 196
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [DW-1:0]   i_rem,
    input  logic [NW-1:0]   i_num,
    input  logic [QW-1:0]   i_q,
    input  logic [DW-1:0]   i_d,
    input  logic [SBW-1:0]  i_sb,
    output logic            o_valid,
    output logic [DW-1:0]   o_rem,
    output logic [NW-1:0]   o_num,
    output logic [QW-1:0]   o_q,
    output logic [DW-1:0]   o_d,
    output logic [SBW-1:0]  o_sb
);
    import vpr_pkg::*;

    logic [DW:0]   trial, diff;
    logic          ge;
    logic          r_valid;
    logic [DW-1:0] r_rem, r_d, n_rem;
    logic [NW-1:0] r_num;
    logic [QW-1:0] r_q;
    logic [SBW-1:0] r_sb;

    always_comb begin
        trial = {i_rem, i_num[NW-1]};
        diff  = trial - {1'b0, i_d};
        ge    = (trial >= {1'b0, i_d});
        n_rem = ge ? diff[DW-1:0] : trial[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_num <= i_num << 1;
            r_q   <= {i_q[QW-2:0], ge};
            r_d   <= i_d;
            r_sb  <= i_sb;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_num   = r_num;
    assign o_q     = r_q;
    assign o_d     = r_d;
    assign o_sb    = r_sb;
endmodule

FILE: src/vpr_scale.sv
// s*b by partial products, clamp, optional a - s*b, saturation and output register
module vpr_scale #(
    parameter int W   = 32,
    parameter int F   = 16,
    parameter int QW  = 64,
    parameter int SBW = 6 * W + 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [QW-1:0]               i_q,
    input  logic [SBW-1:0]              i_sb,
    output logic                        o_valid,
    output logic [vpr_pkg::FIELD_W-1:0] o_res_x,
    output logic [vpr_pkg::FIELD_W-1:0] o_res_y,
    output logic [vpr_pkg::FIELD_W-1:0] o_res_z,
    output logic [1:0]                  o_status,
    output logic                        o_batch_end_out
);
    import vpr_pkg::*;

    localparam int HW  = QW - HALF_W;
    localparam int PW  = QW + W;
    localparam int MW  = CLAMP_BITS + 1;
    localparam int RW  = CLAMP_BITS + 3;
    localparam logic [PW-1:0] CLAMP_P = PW'(1) << CLAMP_BITS;
    localparam logic signed [RW-1:0] SAT_HI = (RW'(1) <<< (W - 1)) - RW'(1);
    localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);

    logic [2:0][W-1:0] in_a, in_b;
    logic              in_mode, in_be, in_bzero, in_neg;
    logic [W-1:0]      bm [3];

    logic                   r1_valid, r2_valid, r3_valid;
    logic [HALF_W+W-1:0]    r1_pl [3];
    logic [HW+W-1:0]        r1_ph [3];
    logic [2:0]             r1_neg, r2_neg;
    logic [2:0][W-1:0]      r1_a, r2_a;
    logic                   r1_mode, r2_mode, r1_be, r2_be, r1_bzero, r2_bzero;
    logic [PW-1:0]          prod [3];
    logic [PW-1:0]          sh [3];
    logic [MW-1:0]          n2_m [3];
    logic [MW-1:0]          r2_m [3];
    logic signed [RW-1:0]   pv [3];
    logic signed [RW-1:0]   rv [3];
    logic [W-1:0]           res [3];
    logic [2:0]             sat;
    logic [FIELD_W-1:0]     r3_x, r3_y, r3_z;
    t_status                r3_status, n3_status;
    logic                   r3_be;

    assign {in_mode, in_be, in_bzero, in_neg, in_a, in_b} = i_sb;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            bm[i] = in_b[i][W-1] ? -in_b[i] : in_b[i];
        end
    end

    // products split on the quotient halves; clamp at 2^40 after the shift
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            prod[i] = PW'(r1_pl[i]) + (PW'(r1_ph[i]) << HALF_W);
            sh[i]   = prod[i] >> F;
            n2_m[i] = (sh[i] > CLAMP_P) ? CLAMP_P[MW-1:0] : sh[i][MW-1:0];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pv[i]  = r2_neg[i] ? -$signed({2'b00, r2_m[i]}) : $signed({2'b00, r2_m[i]});
            rv[i]  = r2_mode ? RW'($signed(r2_a[i])) - pv[i] : pv[i];
            sat[i] = (rv[i] > SAT_HI) || (rv[i] < SAT_LO);
            if (rv[i] > SAT_HI) begin
                res[i] = SAT_HI[W-1:0];
            end else if (rv[i] < SAT_LO) begin
                res[i] = SAT_LO[W-1:0];
            end else begin
                res[i] = rv[i][W-1:0];
            end
            if (r2_bzero) begin
                res[i] = '0;
            end
        end
        priority if (r2_bzero) begin
            n3_status = ST_BZERO;
        end else if (sat != 3'b000) begin
            n3_status = ST_SAT;
        end else begin
            n3_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_pl[i]  <= i_q[HALF_W-1:0] * bm[i];
                r1_ph[i]  <= i_q[QW-1:HALF_W] * bm[i];
                r1_neg[i] <= in_neg ^ in_b[i][W-1];
                r2_m[i]   <= n2_m[i];
            end
            r1_a      <= in_a;
            r1_mode   <= in_mode;
            r1_be     <= in_be;
            r1_bzero  <= in_bzero;
            r2_neg    <= r1_neg;
            r2_a      <= r1_a;
            r2_mode   <= r1_mode;
            r2_be     <= r1_be;
            r2_bzero  <= r1_bzero;
            r3_x      <= FIELD_W'($signed(res[0]));
            r3_y      <= FIELD_W'($signed(res[1]));
            r3_z      <= FIELD_W'($signed(res[2]));
            r3_status <= n3_status;
            r3_be     <= r2_be;
        end
    end

    assign o_valid         = r3_valid;
    assign o_res_x         = r3_x;
    assign o_res_y         = r3_y;
    assign o_res_z         = r3_z;
    assign o_status        = r3_status;
    assign o_batch_end_out = r3_be;
endmodule

FILE: src/vector_projection_rejection.sv
// top level: projection / rejection of 3d fixed-point vectors
//
// input channel: i_valid / o_stall carry mode, a, b and the batch_end mark;
// a transfer happens on a clock edge with i_valid high and o_stall low.
// output channel: o_valid / i_stall carry res_x/y/z, status and batch_end_out.
// one result comes out for every input transfer, in order.
// the pipeline has three stages of products and dot sums, one stage per
// quotient bit of the restoring divider for dot(a,b)/dot(b,b), and three
// stages of scale, subtract and saturate ending in the output register.
// throughput is one pair per cycle while the output is not stalled; the whole pipeline advances together.
// when the receiver stalls a valid result, the pipeline freezes and o_stall
// rises in the same cycle, so nothing is lost or repeated.
// status: ok, b is the zero vector (results zero), or a component saturated.
// reset (synchronous, active low) clears all valid bits; no flush needed.
module vector_projection_rejection #(
    parameter int COMP_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_mode,
    input  logic [vpr_pkg::FIELD_W-1:0] i_a_x,
    input  logic [vpr_pkg::FIELD_W-1:0] i_a_y,
    input  logic [vpr_pkg::FIELD_W-1:0] i_a_z,
    input  logic [vpr_pkg::FIELD_W-1:0] i_b_x,
    input  logic [vpr_pkg::FIELD_W-1:0] i_b_y,
    input  logic [vpr_pkg::FIELD_W-1:0] i_b_z,
    input  logic                        i_batch_end,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [vpr_pkg::FIELD_W-1:0] o_res_x,
    output logic [vpr_pkg::FIELD_W-1:0] o_res_y,
    output logic [vpr_pkg::FIELD_W-1:0] o_res_z,
    output logic [1:0]                  o_status,
    output logic                        o_batch_end_out
);
    import vpr_pkg::*;

    localparam int W   = COMP_WIDTH;
    localparam int DW  = 2 * W;
    localparam int NW  = DW + FRAC_BITS;
    localparam int QW  = (NW > 64) ? 64 : NW;
    localparam int SBW = 6 * W + 4;

    logic              en;
    logic [2:0][W-1:0] a_in, b_in;

    logic              d_valid [NW+1];
    logic [DW-1:0]     d_rem   [NW+1];
    logic [NW-1:0]     d_num   [NW+1];
    logic [QW-1:0]     d_q     [NW+1];
    logic [DW-1:0]     d_d     [NW+1];
    logic [SBW-1:0]    d_sb    [NW+1];

    // global advance: hold everything while the output transfer is stalled
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    assign a_in = {i_a_z[W-1:0], i_a_y[W-1:0], i_a_x[W-1:0]};
    assign b_in = {i_b_z[W-1:0], i_b_y[W-1:0], i_b_x[W-1:0]};

    vpr_dot #(
        .W(W), .F(FRAC_BITS), .DW(DW), .NW(NW), .SBW(SBW)
    ) u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_mode  (i_mode),
        .i_be    (i_batch_end),
        .i_a     (a_in),
        .i_b     (b_in),
        .o_valid (d_valid[0]),
        .o_num   (d_num[0]),
        .o_d     (d_d[0]),
        .o_sb    (d_sb[0])
    );

    assign d_rem[0] = '0;
    assign d_q[0]   = '0;

    for (genvar k = 0; k < NW; k++) begin : g_div
        vpr_div_stage #(
            .DW(DW), .NW(NW), .QW(QW), .SBW(SBW)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (d_valid[k]),
            .i_rem   (d_rem[k]),
            .i_num   (d_num[k]),
            .i_q     (d_q[k]),
            .i_d     (d_d[k]),
            .i_sb    (d_sb[k]),
            .o_valid (d_valid[k+1]),
            .o_rem   (d_rem[k+1]),
            .o_num   (d_num[k+1]),
            .o_q     (d_q[k+1]),
            .o_d     (d_d[k+1]),
            .o_sb    (d_sb[k+1])
        );
    end

    vpr_scale #(
        .W(W), .F(FRAC_BITS), .QW(QW), .SBW(SBW)
    ) u_scale (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en),
        .i_valid         (d_valid[NW]),
        .i_q             (d_q[NW]),
        .i_sb            (d_sb[NW]),
        .o_valid         (o_valid),
        .o_res_x         (o_res_x),
        .o_res_y         (o_res_y),
        .o_res_z         (o_res_z),
        .o_status        (o_status),
        .o_batch_end_out (o_batch_end_out)
    );
endmodule

FILE: src/vpr_checker.sv
// port-level checks for the projection / rejection block, bound to the top level
module vpr_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_stall,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [vpr_pkg::FIELD_W-1:0] o_res_x,
    input logic [vpr_pkg::FIELD_W-1:0] o_res_y,
    input logic [vpr_pkg::FIELD_W-1:0] o_res_z,
    input logic [1:0]                  o_status
);
    import vpr_pkg::*;

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // input side only stalls while a result waits on a stalled receiver
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a stalled result");

    // zero b gives zero components
    a_bzero_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_BZERO) |->
        (o_res_x == '0 && o_res_y == '0 && o_res_z == '0))
        else $error("zero b with nonzero result");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_res_x) && $stable(o_res_y)
        && $stable(o_res_z) && $stable(o_status)))
        else $error("stalled result changed");
endmodule

bind vector_projection_rejection vpr_checker u_vpr_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_stall  (o_stall),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_res_x  (o_res_x),
    .o_res_y  (o_res_y),
    .o_res_z  (o_res_z),
    .o_status (o_status)
);
